// ===== design/sme_pkg.sv =====
// Shared types and constants for the stack machine execution unit.
// Depends on nothing; used by stack_machine_execute and sme_muldiv.
`default_nettype none
package sme_pkg;

  localparam int unsigned DATA_W = 64;
  localparam int unsigned ADDR_W = 32;

  // opcodes
  localparam logic [4:0] OP_PUSH      = 5'd0;
  localparam logic [4:0] OP_DROP      = 5'd1;
  localparam logic [4:0] OP_DUP       = 5'd2;
  localparam logic [4:0] OP_SWAP      = 5'd3;
  localparam logic [4:0] OP_SEEK      = 5'd4;
  localparam logic [4:0] OP_ADD       = 5'd5;
  localparam logic [4:0] OP_SUB       = 5'd6;
  localparam logic [4:0] OP_MUL       = 5'd7;
  localparam logic [4:0] OP_DIV       = 5'd8;
  localparam logic [4:0] OP_REM       = 5'd9;
  localparam logic [4:0] OP_AND       = 5'd10;
  localparam logic [4:0] OP_OR        = 5'd11;
  localparam logic [4:0] OP_XOR       = 5'd12;
  localparam logic [4:0] OP_SHL       = 5'd13;
  localparam logic [4:0] OP_SHR       = 5'd14;
  localparam logic [4:0] OP_CHECK_EQ  = 5'd15;
  localparam logic [4:0] OP_JMP       = 5'd16;
  localparam logic [4:0] OP_JZ        = 5'd17;
  localparam logic [4:0] OP_JNZ       = 5'd18;
  localparam logic [4:0] OP_JGT       = 5'd19;
  localparam logic [4:0] OP_JGE       = 5'd20;
  localparam logic [4:0] OP_JLT       = 5'd21;
  localparam logic [4:0] OP_JLE       = 5'd22;

  // status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_ZERO_OFS = 3'd1;
  localparam logic [2:0] ST_ASSERT   = 3'd2;
  localparam logic [2:0] ST_UNKNOWN  = 3'd3;
  localparam logic [2:0] ST_UNDER    = 3'd4;
  localparam logic [2:0] ST_OVER     = 3'd5;
  localparam logic [2:0] ST_DIVZERO  = 3'd6;

  localparam logic [ADDR_W-1:0] LEN_SHORT = 32'd1;
  localparam logic [ADDR_W-1:0] LEN_LONG  = 32'd9;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_RD0, S_RD1, S_RD2, S_EXEC, S_MD,
    S_WR, S_WR2, S_RDT, S_CAP, S_FIN
  } state_t;

  typedef struct packed {
    logic start;
    logic is_div;
    logic want_rem;
  } md_req_t;

  typedef struct packed {
    logic              done;
    logic [DATA_W-1:0] result;
  } md_rsp_t;

  // Simple ALU ops, computed combinationally (mul, div and rem go to the iterative unit)
  function automatic logic [DATA_W-1:0] alu_simple(input logic [4:0] op,
                                                   input logic [DATA_W-1:0] a,
                                                   input logic [DATA_W-1:0] b);
    logic [DATA_W-1:0] r;
    case (op)
      OP_ADD:  r = a + b;
      OP_SUB:  r = a - b;
      OP_AND:  r = a & b;
      OP_OR:   r = a | b;
      OP_XOR:  r = a ^ b;
      OP_SHL:  r = a << b[5:0];
      default: r = a >> b[5:0];
    endcase
    return r;
  endfunction

  function automatic logic jump_cond(input logic [4:0] op, input logic [DATA_W-1:0] t);
    logic neg;
    logic zero;
    logic r;
    neg  = t[DATA_W-1];
    zero = (t == '0);
    case (op)
      OP_JZ:   r = zero;
      OP_JNZ:  r = !zero;
      OP_JGT:  r = !neg && !zero;
      OP_JGE:  r = !neg;
      OP_JLT:  r = neg;
      default: r = neg || zero;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== design/stack_machine_execute.sv =====
// Stack machine execution unit: one instruction per beat on a 64-bit stack held in RAM.
// Per item: read top and second, execute (mul/div/rem wait on the mul/div unit), write
// back (swap writes twice), read the new top, register the result. One item at a time:
// no new beat is taken until the result moves to the output register. Three stack RAM
// reads per item and the bit-serial mul/div unit set the pace. Reset: count cleared, then
// a clearing pass zeroes all STACK_DEPTH entries before the first input beat is taken.
`default_nettype none
module stack_machine_execute #(
  parameter int unsigned STACK_DEPTH = 256
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [4:0]  in_op,
  input  wire logic [63:0] in_immediate,
  input  wire logic [31:0] in_instr_addr,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [63:0]      out_top_value,
  output logic [8:0]       out_depth,
  output logic             out_branch_taken,
  output logic [31:0]      out_next_addr,
  output logic [2:0]       out_status
);
  localparam int unsigned AW = $clog2(STACK_DEPTH);
  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);

  sme_pkg::state_t state_r, state_nxt;

  // captured instruction
  logic [4:0]  op_r;
  logic [63:0] imm_r;
  logic [31:0] iaddr_r;

  logic [CW-1:0] count_r;
  logic [AW-1:0] clr_idx_r;
  logic [63:0]   a_r, b_r;     // second and top of stack

  // planned write-back
  logic          wr_en_r, swap_r, md_r;
  logic [AW-1:0] wr_addr_r;
  logic [63:0]   wr_data_r;
  logic [2:0]    status_r;
  logic          taken_r;
  logic [31:0]   next_r;
  logic [63:0]   top_r;

  // outputs
  logic        out_valid_r;
  logic [63:0] out_top_r;
  logic [8:0]  out_depth_r;
  logic        out_taken_r;
  logic [31:0] out_next_r;
  logic [2:0]  out_status_r;

  // RAM port
  logic          ram_we;
  logic [AW-1:0] ram_wa, ram_ra;
  logic [63:0]   ram_wd, ram_rd;

  sme_pkg::md_req_t md_req;
  sme_pkg::md_rsp_t md_rsp;

  logic in_fire, out_free;
  assign in_fire  = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  logic [AW-1:0] top_addr, sec_addr, new_top_addr;
  assign top_addr     = AW'(count_r - CW'(1));
  assign sec_addr     = AW'(count_r - CW'(2));
  assign new_top_addr = AW'(count_r - CW'(1));

  // ---------------- execute decode ----------------
  logic [2:0]    ex_status;
  logic [CW-1:0] ex_cnt;
  logic          ex_we, ex_swap, ex_md, ex_taken, ex_long, ex_go;
  logic [AW-1:0] ex_addr;
  logic [63:0]   ex_data, seek_mag;
  logic [31:0]   ex_next;
  logic          cnt_empty, cnt_lt2, cnt_full;

  assign cnt_empty = (count_r == '0);
  assign cnt_lt2   = (count_r < CW'(2));
  assign cnt_full  = (count_r == CW'(STACK_DEPTH));
  assign seek_mag  = 64'd0 - imm_r;

  always_comb begin
    ex_status = sme_pkg::ST_OK;
    ex_cnt    = count_r;
    ex_we     = 1'b0;
    ex_swap   = 1'b0;
    ex_md     = 1'b0;
    ex_taken  = 1'b0;
    ex_long   = 1'b0;
    ex_go     = 1'b0;
    ex_addr   = sec_addr;
    ex_data   = sme_pkg::alu_simple(op_r, a_r, b_r);
    case (op_r) inside
      sme_pkg::OP_PUSH: begin
        ex_long = 1'b1;
        if (cnt_full) begin
          ex_status = sme_pkg::ST_OVER;
        end else begin
          ex_we   = 1'b1;
          ex_addr = AW'(count_r);
          ex_data = imm_r;
          ex_cnt  = count_r + CW'(1);
        end
      end
      sme_pkg::OP_DROP: begin
        if (cnt_empty) ex_status = sme_pkg::ST_UNDER;
        else ex_cnt = count_r - CW'(1);
      end
      sme_pkg::OP_DUP: begin
        if (cnt_empty) begin
          ex_status = sme_pkg::ST_UNDER;
        end else if (cnt_full) begin
          ex_status = sme_pkg::ST_OVER;
        end else begin
          ex_we   = 1'b1;
          ex_addr = AW'(count_r);
          ex_data = b_r;
          ex_cnt  = count_r + CW'(1);
        end
      end
      sme_pkg::OP_SWAP: begin
        if (cnt_lt2) begin
          ex_status = sme_pkg::ST_UNDER;
        end else begin
          ex_we   = 1'b1;
          ex_swap = 1'b1;
          ex_addr = top_addr;
          ex_data = a_r;
        end
      end
      sme_pkg::OP_SEEK: begin
        ex_long = 1'b1;
        if (imm_r[63]) begin
          if (seek_mag > 64'(count_r)) ex_status = sme_pkg::ST_UNDER;
          else ex_cnt = count_r - CW'(seek_mag);
        end else begin
          if (imm_r > (64'(STACK_DEPTH) - 64'(count_r))) ex_status = sme_pkg::ST_OVER;
          else ex_cnt = count_r + CW'(imm_r);
        end
      end
      [sme_pkg::OP_ADD:sme_pkg::OP_SHR]: begin
        if (cnt_lt2) begin
          ex_status = sme_pkg::ST_UNDER;
        end else if ((op_r == sme_pkg::OP_DIV || op_r == sme_pkg::OP_REM) && b_r == '0) begin
          ex_status = sme_pkg::ST_DIVZERO;
        end else begin
          ex_we  = 1'b1;
          ex_cnt = count_r - CW'(1);
          ex_md  = (op_r == sme_pkg::OP_MUL || op_r == sme_pkg::OP_DIV ||
                    op_r == sme_pkg::OP_REM);
        end
      end
      sme_pkg::OP_CHECK_EQ: begin
        if (cnt_lt2) ex_status = sme_pkg::ST_UNDER;
        else if (a_r != b_r) ex_status = sme_pkg::ST_ASSERT;
      end
      [sme_pkg::OP_JMP:sme_pkg::OP_JLE]: begin
        ex_long = 1'b1;
        if (op_r == sme_pkg::OP_JMP) begin
          ex_go = 1'b1;
        end else if (cnt_empty) begin
          ex_status = sme_pkg::ST_UNDER;
        end else begin
          ex_go = sme_pkg::jump_cond(op_r, b_r);
        end
        if (ex_go) begin
          if (imm_r == '0) ex_status = sme_pkg::ST_ZERO_OFS;
          else ex_taken = 1'b1;
        end
      end
      default: ex_status = sme_pkg::ST_UNKNOWN;
    endcase
    if (ex_taken) ex_next = iaddr_r + imm_r[31:0];
    else ex_next = iaddr_r + (ex_long ? sme_pkg::LEN_LONG : sme_pkg::LEN_SHORT);
  end

  // ---------------- next state ----------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      sme_pkg::S_CLEAR: if (clr_idx_r == AW'(STACK_DEPTH - 1)) state_nxt = sme_pkg::S_IDLE;
      sme_pkg::S_IDLE:  if (in_fire) state_nxt = sme_pkg::S_RD0;
      sme_pkg::S_RD0:   state_nxt = sme_pkg::S_RD1;
      sme_pkg::S_RD1:   state_nxt = sme_pkg::S_RD2;
      sme_pkg::S_RD2:   state_nxt = sme_pkg::S_EXEC;
      sme_pkg::S_EXEC:  state_nxt = ex_md ? sme_pkg::S_MD : sme_pkg::S_WR;
      sme_pkg::S_MD:    if (md_rsp.done) state_nxt = sme_pkg::S_WR;
      sme_pkg::S_WR:    state_nxt = swap_r ? sme_pkg::S_WR2 : sme_pkg::S_RDT;
      sme_pkg::S_WR2:   state_nxt = sme_pkg::S_RDT;
      sme_pkg::S_RDT:   state_nxt = sme_pkg::S_CAP;
      sme_pkg::S_CAP:   state_nxt = sme_pkg::S_FIN;
      sme_pkg::S_FIN:   if (out_free) state_nxt = sme_pkg::S_IDLE;
      default:          state_nxt = sme_pkg::S_CLEAR;
    endcase
  end

  // ---------------- FSM outputs ----------------
  always_comb begin
    in_ready      = 1'b0;
    ram_we        = 1'b0;
    ram_wa        = wr_addr_r;
    ram_wd        = wr_data_r;
    ram_ra        = top_addr;
    md_req.start  = 1'b0;
    md_req.is_div = (op_r == sme_pkg::OP_DIV || op_r == sme_pkg::OP_REM);
    md_req.want_rem = (op_r == sme_pkg::OP_REM);
    case (state_r)
      sme_pkg::S_CLEAR: begin
        ram_we = 1'b1;
        ram_wa = clr_idx_r;
        ram_wd = '0;
      end
      sme_pkg::S_IDLE: in_ready = 1'b1;
      sme_pkg::S_RD0:  ram_ra = top_addr;
      sme_pkg::S_RD1:  ram_ra = sec_addr;
      sme_pkg::S_EXEC: md_req.start = ex_md;
      sme_pkg::S_WR:   ram_we = wr_en_r;
      sme_pkg::S_WR2: begin
        // swap second half: old top goes one below
        ram_we = 1'b1;
        ram_wa = wr_addr_r - AW'(1);
        ram_wd = b_r;
      end
      sme_pkg::S_RDT:  ram_ra = new_top_addr;
      default: ;
    endcase
  end

  // ---------------- registers ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sme_pkg::S_CLEAR;
      clr_idx_r   <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == sme_pkg::S_CLEAR) clr_idx_r <= clr_idx_r + AW'(1);
      if (state_r == sme_pkg::S_EXEC) count_r <= ex_cnt;
      if (state_r == sme_pkg::S_FIN && out_free) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_r    <= in_op;
      imm_r   <= in_immediate;
      iaddr_r <= in_instr_addr;
    end
    if (state_r == sme_pkg::S_RD1) b_r <= ram_rd;
    if (state_r == sme_pkg::S_RD2) a_r <= ram_rd;
    if (state_r == sme_pkg::S_EXEC) begin
      wr_en_r   <= ex_we;
      swap_r    <= ex_swap;
      md_r      <= ex_md;
      wr_addr_r <= ex_addr;
      wr_data_r <= ex_data;
      status_r  <= ex_status;
      taken_r   <= ex_taken;
      next_r    <= ex_next;
    end
    if (state_r == sme_pkg::S_MD && md_rsp.done) wr_data_r <= md_rsp.result;
    if (state_r == sme_pkg::S_CAP) top_r <= (count_r == '0) ? '0 : ram_rd;
    if (state_r == sme_pkg::S_FIN && out_free) begin
      out_top_r    <= top_r;
      out_depth_r  <= 9'(count_r);
      out_taken_r  <= taken_r;
      out_next_r   <= next_r;
      out_status_r <= status_r;
    end
  end

  sme_ram #(.WIDTH(64), .DEPTH(STACK_DEPTH)) u_stack (
    .clk     (clk),
    .we      (ram_we),
    .wr_addr (ram_wa),
    .wr_data (ram_wd),
    .rd_addr (ram_ra),
    .rd_data (ram_rd)
  );

  sme_muldiv u_md (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (md_req),
    .a     (a_r),
    .b     (b_r),
    .rsp   (md_rsp)
  );

  assign out_valid        = out_valid_r;
  assign out_top_value    = out_top_r;
  assign out_depth        = out_depth_r;
  assign out_branch_taken = out_taken_r;
  assign out_next_addr    = out_next_r;
  assign out_status       = out_status_r;

  // ---------------- checks ----------------
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(STACK_DEPTH))
    else $error("stack count beyond depth");

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_ready)
    else $error("second beat taken while busy");

  a_md_only_muldiv: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == sme_pkg::S_MD) |-> md_r)
    else $error("mul/div wait without mul/div op");

  a_unknown_no_branch: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == sme_pkg::ST_UNKNOWN) |-> !out_branch_taken)
    else $error("unknown op reported a taken branch");

endmodule
`default_nettype wire

// ===== design/sme_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module sme_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end
endmodule
`default_nettype wire

// ===== design/sme_muldiv.sv =====
// Iterative 64-bit multiplier / unsigned divider, one bit per cycle.
// Depends on sme_pkg.
`default_nettype none
module sme_muldiv (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire sme_pkg::md_req_t          req,
  input  wire logic [sme_pkg::DATA_W-1:0] a,
  input  wire logic [sme_pkg::DATA_W-1:0] b,
  output sme_pkg::md_rsp_t               rsp
);
  logic [sme_pkg::DATA_W-1:0] acc_r, x_r, y_r;
  logic [5:0]                 cnt_r;
  logic                       busy_r, done_r, div_r, rem_r;
  logic [sme_pkg::DATA_W:0]   trial;

  // restoring step: shifted partial remainder minus divisor
  assign trial = {acc_r, x_r[sme_pkg::DATA_W-1]} - {1'b0, y_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 6'd1;
        if (cnt_r == 6'd63) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      acc_r <= '0;
      x_r   <= a;
      y_r   <= b;
      div_r <= req.is_div;
      rem_r <= req.want_rem;
    end else if (busy_r) begin
      if (div_r) begin
        if (!trial[sme_pkg::DATA_W]) begin
          acc_r <= trial[sme_pkg::DATA_W-1:0];
          x_r   <= {x_r[sme_pkg::DATA_W-2:0], 1'b1};
        end else begin
          acc_r <= {acc_r[sme_pkg::DATA_W-2:0], x_r[sme_pkg::DATA_W-1]};
          x_r   <= {x_r[sme_pkg::DATA_W-2:0], 1'b0};
        end
      end else begin
        // shift-add: x holds the shifted multiplicand, y the multiplier
        if (y_r[0]) begin
          acc_r <= acc_r + x_r;
        end
        x_r <= {x_r[sme_pkg::DATA_W-2:0], 1'b0};
        y_r <= {1'b0, y_r[sme_pkg::DATA_W-1:1]};
      end
    end
  end

  assign rsp.done   = done_r;
  assign rsp.result = (div_r && !rem_r) ? x_r : acc_r;
endmodule
`default_nettype wire
